### rtl/core/spt_pkg.sv
package spt_pkg;

    // byte roles reported on the result channel
    localparam logic [1:0] ROLE_OPCODE  = 2'd0;
    localparam logic [1:0] ROLE_HEADER  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

    // script opcodes that open a push
    localparam logic [7:0] OP_PUSH_MIN   = 8'h01;
    localparam logic [7:0] OP_PUSH_MAX   = 8'h4b;
    localparam logic [7:0] OP_PUSH_LEN1  = 8'h4c;
    localparam logic [7:0] OP_PUSH_LEN2  = 8'h4d;
    localparam logic [7:0] OP_PUSH_LEN4  = 8'h4e;

    // length field sizes in bytes
    localparam logic [2:0] LEN_BYTES_1 = 3'd1;
    localparam logic [2:0] LEN_BYTES_2 = 3'd2;
    localparam logic [2:0] LEN_BYTES_4 = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LEN  = 3'b010,
        PH_PAY  = 3'b100
    } phase_t;

endpackage

### rtl/core/script_push_tokenizer.sv
// Script push tokeniser: takes one script byte per transaction on the s_ channel and returns
// one result per byte on the m_ channel in the cycle after acceptance, giving the byte's role
// (opcode, push header or length byte, payload), the decoded push length when a header
// completes, chunk end, script end and a truncation flag when the script ends inside a length
// field or payload. A byte can be accepted every cycle; s_ready only drops while a result
// waits unaccepted in the output register. cfg_wdata[0] selects big-endian PUSHDATA2/4 length
// fields (reset: little-endian) and should only be written while the block is idle.
module script_push_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_script_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_byte_role,
    output logic [7:0]  m_byte_value,
    output logic [31:0] m_push_length,
    output logic        m_length_ready,
    output logic        m_chunk_end,
    output logic        m_script_end,
    output logic        m_truncated
);
    import spt_pkg::*;

    logic        big_endian_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] pay_left_reg, pay_left_next;

    logic        m_valid_reg;
    logic [1:0]  role_reg, role_next;
    logic [7:0]  value_reg;
    logic [31:0] plen_reg, plen_next;
    logic        lready_reg, lready_next;
    logic        cend_reg, cend_next;
    logic        send_reg;
    logic        trunc_reg, trunc_next;

    logic        accept;
    logic [2:0]  len_left_dec;
    logic [31:0] pay_left_dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign len_left_dec = len_left_reg - 3'd1;
    assign pay_left_dec = pay_left_reg - 32'd1;

    always_comb begin
        phase_next    = phase_reg;
        len_left_next = len_left_reg;
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        pay_left_next = pay_left_reg;
        role_next     = ROLE_OPCODE;
        plen_next     = '0;
        lready_next   = 1'b0;
        cend_next     = 1'b0;
        trunc_next    = 1'b0;

        unique case (phase_reg)
            PH_LEN: begin
                role_next = ROLE_HEADER;
                if (big_endian_reg) begin
                    acc_next = {acc_reg[23:0], s_script_byte};
                end else begin
                    acc_next = acc_reg | ({24'd0, s_script_byte} << {pos_reg, 3'b000});
                end
                pos_next      = pos_reg + 2'd1;
                len_left_next = len_left_dec;
                if (len_left_dec == 3'd0) begin
                    lready_next   = 1'b1;
                    plen_next     = acc_next;
                    pay_left_next = acc_next;
                    if (acc_next == 32'd0) begin
                        cend_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                role_next     = ROLE_PAYLOAD;
                pay_left_next = pay_left_dec;
                if (pay_left_dec == 32'd0) begin
                    cend_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (s_script_byte >= OP_PUSH_MIN && s_script_byte <= OP_PUSH_MAX) begin
                    role_next     = ROLE_HEADER;
                    lready_next   = 1'b1;
                    plen_next     = {24'd0, s_script_byte};
                    pay_left_next = {24'd0, s_script_byte};
                    phase_next    = PH_PAY;
                end else if (s_script_byte >= OP_PUSH_LEN1 && s_script_byte <= OP_PUSH_LEN4) begin
                    role_next = ROLE_HEADER;
                    priority if (s_script_byte == OP_PUSH_LEN1) begin
                        len_left_next = LEN_BYTES_1;
                    end else if (s_script_byte == OP_PUSH_LEN2) begin
                        len_left_next = LEN_BYTES_2;
                    end else begin
                        len_left_next = LEN_BYTES_4;
                    end
                    acc_next      = '0;
                    pay_left_next = '0;
                    pos_next      = '0;
                    phase_next    = PH_LEN;
                end else begin
                    cend_next = 1'b1;
                end
            end
        endcase

        // end of script drops any open push and starts afresh
        if (s_last_byte) begin
            trunc_next    = (phase_next != PH_IDLE);
            phase_next    = PH_IDLE;
            len_left_next = '0;
            pos_next      = '0;
            acc_next      = '0;
            pay_left_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            len_left_reg   <= '0;
            pos_reg        <= '0;
            acc_reg        <= '0;
            pay_left_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                big_endian_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg    <= phase_next;
                len_left_reg <= len_left_next;
                pos_reg      <= pos_next;
                acc_reg      <= acc_next;
                pay_left_reg <= pay_left_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            role_reg   <= role_next;
            value_reg  <= s_script_byte;
            plen_reg   <= plen_next;
            lready_reg <= lready_next;
            cend_reg   <= cend_next;
            send_reg   <= s_last_byte;
            trunc_reg  <= trunc_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_role    = role_reg;
    assign m_byte_value   = value_reg;
    assign m_push_length  = plen_reg;
    assign m_length_ready = lready_reg;
    assign m_chunk_end    = cend_reg;
    assign m_script_end   = send_reg;
    assign m_truncated    = trunc_reg;

endmodule

### rtl/core/spt_checker.sv
module spt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_script_byte,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_byte_role,
    input logic [7:0]  m_byte_value,
    input logic [31:0] m_push_length,
    input logic        m_length_ready,
    input logic        m_chunk_end,
    input logic        m_script_end,
    input logic        m_truncated
);
    import spt_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_value) && $stable(m_byte_role)
            && $stable(m_push_length))
        else $error("result changed while stalled");

    // every accepted byte shows up as the next result
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid && m_byte_value == $past(s_script_byte)
            && m_script_end == $past(s_last_byte))
        else $error("accepted byte not reflected in next result");

    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_length_ready |-> m_push_length == 32'd0)
        else $error("push length shown without header completion");

    // a header may complete on the last byte and still leave its payload open
    a_len_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_length_ready |-> m_byte_role == ROLE_HEADER)
        else $error("header completion on wrong byte role");

    a_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_script_end && !m_chunk_end && m_byte_role != ROLE_OPCODE)
        else $error("truncation flagged on a finished chunk");

endmodule

bind script_push_tokenizer spt_checker u_spt_checker (.*);
